// ===== rtl/rrr_pkg.sv =====
// rrr_pkg: request and result types, stage widths and the saturation helper
// for the ray reflect/refract pipeline; depends on nothing else
package rrr_pkg;

  localparam int unsigned PIPE_DEPTH  = 18;
  localparam int unsigned SQRT_STAGES = 8;
  localparam int unsigned SQRT_STEPS  = 3;
  localparam int unsigned RAD_W       = 48;
  localparam int unsigned ROOT_W      = 24;
  localparam int unsigned REM_W       = 26;
  localparam int unsigned PERP_W      = 23;

  localparam logic OP_REFLECT = 1'b0;
  localparam logic OP_REFRACT = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        index_ratio;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_t;

  // per-request side data that travels down the pipe
  typedef struct packed {
    logic                    op;
    logic [15:0]             eta;
    logic [2:0][15:0]        dir;
    logic [2:0][15:0]        nrm;
    logic [2:0][15:0]        refl;
    logic [2:0][PERP_W-1:0]  perp;
  } carry_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ray_reflect_refract.sv =====
// ray_reflect_refract: pipelined reflect / snell refract of one ray per cycle
// when not stalled; uses rrr_pkg for request/result types, widths, saturation
//
// usage:
//   in_valid/in_stall/in_data carry one request: operation, direction,
//   normal and index ratio, all Q2.14. out_valid/out_stall/out_data return
//   one scattered direction per request, in order, saturated to Q2.14.
//   one request can be taken every cycle while the pipe is not held. the
//   stage count is set by the dot product, the chained multiplies of the
//   refract path and the 24-step square root, which is split over 8 stages
//   of 3 steps. reset (rst_n low, synchronous) empties the pipe; no data is
//   kept between requests. while out_valid is high and out_stall is high the
//   whole pipe holds, bubbles included, and in_stall is raised; nothing is
//   taken until the held result leaves.
module ray_reflect_refract (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rrr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rrr_pkg::out_t out_data
);

  localparam int unsigned ND = rrr_pkg::PIPE_DEPTH;
  localparam int unsigned NS = rrr_pkg::SQRT_STAGES;
  localparam int unsigned RW = rrr_pkg::RAD_W;
  localparam int unsigned QW = rrr_pkg::ROOT_W;
  localparam int unsigned MW = rrr_pkg::REM_W;
  localparam int unsigned PW = rrr_pkg::PERP_W;

  logic                 en;
  logic [ND:1]          v_r;
  rrr_pkg::carry_t      carry_r   [1:ND-1];
  rrr_pkg::carry_t      carry_nxt [1:ND-1];

  logic signed [2:0][31:0] prod_r;
  logic signed [33:0]      dot_r;
  logic signed [2:0][51:0] kn_r;
  logic signed [2:0][33:0] t_r;
  logic signed [2:0][50:0] te_r;
  logic signed [2:0][45:0] sq_r;
  logic [RW-1:0]           rad_r [0:NS];
  logic [QW-1:0]           q_r   [0:NS];
  logic [MW-1:0]           rem_r [0:NS];
  logic signed [2:0][41:0] sn_r;
  rrr_pkg::out_t           out_data_r;

  // stage comb results
  logic signed [2:0][31:0] prod_nxt;
  logic signed [33:0]      dot_nxt;
  logic signed [2:0][51:0] kn_nxt;
  logic signed [2:0][33:0] t_nxt;
  logic signed [2:0][50:0] te_nxt;
  logic signed [2:0][45:0] sq_nxt;
  logic [RW-1:0]           m_nxt;
  logic signed [2:0][41:0] sn_nxt;
  rrr_pkg::out_t           out_data_nxt;
  logic [RW-1:0]           rad_nxt [1:NS];
  logic [QW-1:0]           q_nxt   [1:NS];
  logic [MW-1:0]           rem_nxt [1:NS];

  assign en        = !(v_r[ND] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v_r[ND];
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ND-1:1], in_valid};
    end
  end

  // reflect rounding from Q.42 to Q.14 of the same sum that feeds t
  function automatic logic signed [24:0] kn_acc_refl(input int i);
    logic signed [52:0] acc;
    acc = ($signed({{37{carry_r[3].dir[i][15]}}, carry_r[3].dir[i]}) <<< 28)
        + 53'($signed(kn_r[i])) + 53'sd134217728;
    return acc[52:28];
  endfunction

  // side data: copied stage to stage, filled where it is produced
  always_comb begin
    carry_nxt[1].op   = in_data.operation;
    carry_nxt[1].eta  = in_data.index_ratio;
    carry_nxt[1].dir  = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
    carry_nxt[1].nrm  = {in_data.normal_z, in_data.normal_y, in_data.normal_x};
    carry_nxt[1].refl = '0;
    carry_nxt[1].perp = '0;
    for (int k = 2; k < ND; k++) begin
      carry_nxt[k] = carry_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      carry_nxt[4].refl[i] = rrr_pkg::sat16(32'($signed(kn_acc_refl(i))));
      carry_nxt[6].perp[i] = te_r[i][50:28] + PW'(te_r[i][27]);
    end
  end

  always_comb begin
    logic signed [34:0] negd;
    logic signed [34:0] cosv;
    logic signed [35:0] kv;
    logic signed [52:0] acc;
    logic signed [44:0] len2;
    logic signed [44:0] diff;
    logic [QW:0]        s;
    logic signed [42:0] acc2;
    logic signed [42:0] rnd;
    logic signed [2:0][15:0] res;
    // dot product terms
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = 32'($signed(carry_nxt[1].dir[i]) * $signed(carry_nxt[1].nrm[i]));
    end
    dot_nxt = 34'($signed(prod_r[0])) + 34'($signed(prod_r[1]))
            + 34'($signed(prod_r[2]));
    // reflect scales n by -2 dot, refract by cos = min(-dot, 1)
    negd = -35'(dot_r);
    cosv = (negd > 35'sd268435456) ? 35'sd268435456 : negd;
    kv   = (carry_r[2].op == rrr_pkg::OP_REFRACT) ? 36'(cosv)
         : -(36'(dot_r) <<< 1);
    for (int i = 0; i < 3; i++) begin
      kn_nxt[i] = 52'(kv * $signed(carry_r[2].nrm[i]));
      acc = ($signed({{37{carry_r[3].dir[i][15]}}, carry_r[3].dir[i]}) <<< 28)
          + 53'($signed(kn_r[i])) + 53'sd8192;
      t_nxt[i]  = acc[47:14];
      te_nxt[i] = 51'($signed(t_r[i]) * $signed({1'b0, carry_r[4].eta}));
      sq_nxt[i] = 46'($signed(carry_r[6].perp[i]) * $signed(carry_r[6].perp[i]));
    end
    len2 = 45'(sq_r[0]) + 45'(sq_r[1]) + 45'(sq_r[2]);
    diff = 45'sd268435456 - len2;
    m_nxt = (diff < 0) ? RW'(-diff) : RW'(diff);
    // nearest-rounded root, then n scaled by it
    s = {1'b0, q_r[NS]} + (QW+1)'(rem_r[NS] > MW'(q_r[NS]));
    for (int i = 0; i < 3; i++) begin
      sn_nxt[i] = 42'($signed({1'b0, s}) * $signed(carry_r[ND-2].nrm[i]));
      acc2 = (43'($signed(carry_r[ND-1].perp[i])) <<< 14) - 43'($signed(sn_r[i]));
      rnd  = acc2 + 43'sd8192;
      res[i] = (carry_r[ND-1].op == rrr_pkg::OP_REFRACT)
             ? rrr_pkg::sat16(32'($signed(rnd[42:14])))
             : $signed(carry_r[ND-1].refl[i]);
    end
    out_data_nxt.out_x = res[0];
    out_data_nxt.out_y = res[1];
    out_data_nxt.out_z = res[2];
  end

  // square root: two radicand bits per step, three steps per stage
  for (genvar j = 1; j <= NS; j++) begin : g_sqrt
    always_comb begin
      logic [RW-1:0] rad;
      logic [QW-1:0] q;
      logic [MW-1:0] rem;
      logic [MW+1:0] r2;
      logic [MW+1:0] trial;
      rad = rad_r[j-1];
      q   = q_r[j-1];
      rem = rem_r[j-1];
      for (int k = 0; k < rrr_pkg::SQRT_STEPS; k++) begin
        r2    = {rem, rad[RW-1:RW-2]};
        trial = {(MW-QW)'(0), q, 2'b01};
        if (r2 >= trial) begin
          rem = MW'(r2 - trial);
          q   = {q[QW-2:0], 1'b1};
        end else begin
          rem = r2[MW-1:0];
          q   = {q[QW-2:0], 1'b0};
        end
        rad = {rad[RW-3:0], 2'b00};
      end
      rad_nxt[j] = rad;
      q_nxt[j]   = q;
      rem_nxt[j] = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k < ND; k++) begin
        carry_r[k] <= carry_nxt[k];
      end
      prod_r     <= prod_nxt;
      dot_r      <= dot_nxt;
      kn_r       <= kn_nxt;
      t_r        <= t_nxt;
      te_r       <= te_nxt;
      sq_r       <= sq_nxt;
      rad_r[0]   <= m_nxt;
      q_r[0]     <= '0;
      rem_r[0]   <= '0;
      for (int j = 1; j <= NS; j++) begin
        rad_r[j] <= rad_nxt[j];
        q_r[j]   <= q_nxt[j];
        rem_r[j] <= rem_nxt[j];
      end
      sn_r       <= sn_nxt;
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a held result");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[1])
    else $error("accepted request lost at pipe entry");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v_r))
    else $error("pipe moved during an output stall");
`endif

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for ray_reflect_refract, reflect and snell refract in Q2.14
// depends on rrr_pkg and the ray_reflect_refract rtl; predicts each result and compares in order
module tb_top;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  rrr_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  rrr_pkg::out_t out_data;

  rrr_pkg::in_t  pending_rays[$];
  rrr_pkg::out_t scatter_due[$];
  int   errors;
  int   n_sent;
  int   n_checked;
  int   idle_pct;
  int   stall_pct;
  bit   hold_off;
  bit   stim_done;

  ray_reflect_refract i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // round to nearest, ties upward; arithmetic shift floors
  function automatic longint rnd_shift(input longint v, input int s);
    longint r;
    r = (v + (longint'(1) <<< (s - 1))) >>> s;
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic longint root_nearest(input longint x);
    longint r;
    longint b;
    longint rem;
    r = 0;
    b = longint'(1) <<< 62;
    rem = x;
    while (b > rem) b = b >>> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    if (rem > r) r = r + 1;
    return r;
  endfunction

  function automatic rrr_pkg::out_t scatter(input rrr_pkg::in_t q);
    longint d[3];
    longint n[3];
    longint dotp;
    longint cosv;
    longint eta;
    longint t;
    longint perp[3];
    longint len2;
    longint m;
    longint s;
    longint c[3];
    rrr_pkg::out_t r;
    d[0] = q.dir_x;    d[1] = q.dir_y;    d[2] = q.dir_z;
    n[0] = q.normal_x; n[1] = q.normal_y; n[2] = q.normal_z;
    dotp = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    if (q.operation == rrr_pkg::OP_REFLECT) begin
      for (int i = 0; i < 3; i++)
        c[i] = rnd_shift((d[i] <<< 28) - 2 * dotp * n[i], 28);
    end else begin
      eta = longint'({48'd0, q.index_ratio});
      cosv = -dotp;
      if (cosv > (longint'(1) <<< 28)) cosv = longint'(1) <<< 28;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        t = rnd_shift((d[i] <<< 28) + cosv * n[i], 14);
        perp[i] = rnd_shift(t * eta, 28);
        len2 += perp[i] * perp[i];
      end
      m = (longint'(1) <<< 28) - len2;
      if (m < 0) m = -m;
      s = root_nearest(m);
      for (int i = 0; i < 3; i++)
        c[i] = rnd_shift((perp[i] <<< 14) - s * n[i], 14);
    end
    r.out_x = clip16(c[0]);
    r.out_y = clip16(c[1]);
    r.out_z = clip16(c[2]);
    return r;
  endfunction

  // driver: valid held with a stalled payload, idle only between requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) begin
        scatter_due.push_back(scatter(in_data));
        n_sent <= n_sent + 1;
      end
      if (pending_rays.size() != 0 && !hold_off &&
          $urandom_range(99) >= idle_pct) begin
        in_data  <= pending_rays.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (scatter_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          if (out_data !== scatter_due[0]) begin
            $display("%0t: expected x=%0d y=%0d z=%0d, actual x=%0d y=%0d z=%0d", $time,
                     scatter_due[0].out_x, scatter_due[0].out_y, scatter_due[0].out_z,
                     out_data.out_x, out_data.out_y, out_data.out_z);
            errors <= errors + 1;
          end
          void'(scatter_due.pop_front());
          n_checked <= n_checked + 1;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [15:0] pick_comp();
    logic signed [15:0] v;
    case ($urandom_range(7))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2: v = 16'sh4000;
      3: v = -16'sh4000;
      4: v = 16'sh0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // mostly components drawn from -1.0..1.0, the rest extreme, zero or random words
  function automatic rrr_pkg::in_t rand_ray();
    rrr_pkg::in_t q;
    q = '0;
    q.operation = 1'($urandom_range(1));
    if ($urandom_range(3) != 0) begin
      q.dir_x = 16'($signed($urandom_range(32768)) - 16384);
      q.dir_y = 16'($signed($urandom_range(32768)) - 16384);
      q.dir_z = 16'($signed($urandom_range(32768)) - 16384);
      q.normal_x = 16'($signed($urandom_range(32768)) - 16384);
      q.normal_y = 16'($signed($urandom_range(32768)) - 16384);
      q.normal_z = 16'($signed($urandom_range(32768)) - 16384);
      q.index_ratio = 16'($urandom_range(8192, 40000));
    end else begin
      q.dir_x = pick_comp();    q.dir_y = pick_comp();    q.dir_z = pick_comp();
      q.normal_x = pick_comp(); q.normal_y = pick_comp(); q.normal_z = pick_comp();
      q.index_ratio = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
    end
    return q;
  endfunction

  function automatic rrr_pkg::in_t mk_ray(input logic op, input int dx, input int dy,
                                          input int dz, input int nx, input int ny,
                                          input int nz, input int eta);
    rrr_pkg::in_t q;
    q.operation = op;
    q.dir_x = 16'(dx); q.dir_y = 16'(dy); q.dir_z = 16'(dz);
    q.normal_x = 16'(nx); q.normal_y = 16'(ny); q.normal_z = 16'(nz);
    q.index_ratio = 16'(eta);
    return q;
  endfunction

  task automatic drain();
    while (pending_rays.size() != 0 || in_valid || scatter_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: plain cases, extremes, total internal reflection, zero eta/normal
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFLECT, 11585, -11585, 0, 0, 16384, 0, 0));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 11585, -11585, 0, 0, 16384, 0,
                                  16384));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 11585, -11585, 0, 0, 16384, 0,
                                  10923));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 15000, -3000, 0, 0, 16384, 0,
                                  24576));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 0, 0, -16384, 0, 0, 16384, 0));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 8000, 9000, -7000, 0, 0, 0, 16384));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFLECT, 8000, 9000, -7000, 0, 0, 0, 65535));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFLECT, 32767, 32767, 32767, 32767, 32767,
                                  32767, 0));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFLECT, -32768, -32768, -32768, -32768,
                                  -32768, -32768, 65535));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 32767, 32767, 32767, 32767, 32767,
                                  32767, 65535));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, -32768, -32768, -32768, -32768,
                                  -32768, -32768, 65535));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, -32768, -32768, -32768, 32767,
                                  32767, 32767, 65535));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 32767, -32768, 0, -32768, 32767, 0,
                                  1));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFLECT, 0, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 0, 0, 0, 0, 0, 0, 65535));
    pending_rays.push_back(mk_ray(rrr_pkg::OP_REFRACT, 5000, 0, 0, -32768, 0, 0, 32768));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 25 : 0;
      stall_pct = (phase == 2) ? 51 : (phase == 3) ? 25 : 0;
      for (int k = 0; k < 435; k++) begin
        pending_rays.push_back(rand_ray());
      end
      if (phase == 2) begin
        // hold the sender off until the pipe has emptied
        while (pending_rays.size() > 200) @(posedge clk);
        hold_off = 1'b1;
        while (in_valid || scatter_due.size() != 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    stall_pct = 0;
    repeat (40) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d rays, reflect and refract, over four idle/stall phases;", n_sent);
    $display("%0d results compared against the fixed point prediction", n_checked);
    if (errors == 0 && scatter_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", scatter_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
